// ----- rtl/aes256_block_encrypt_top_macros.svh -----
// Assertion macros shared by the AES-256 encryption block.
`ifndef AES256_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES256_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AES256_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes256 check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AES256_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes256 check failed");

`endif

// ----- rtl/aes256_pkg.sv -----
// Package with constants, types and round functions of the AES-256 block.
package aes256_pkg;

  localparam int ROUNDS     = 14;
  localparam int KEY_WORDS  = 8;
  localparam int KEY_ROWS   = ROUNDS + 1;
  localparam int ROW_W      = 128;
  localparam int ROW_AW     = $clog2(KEY_ROWS);
  localparam int CNT_W      = 4;
  localparam int KEY_REGS   = 4;
  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiplication by x in GF(256), reduced by the AES polynomial.
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte substitution of one 32-bit word.
  function automatic logic [31:0] sub_word(input logic [31:0] v);
    sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Column mixing of one 32-bit column, first byte most significant.
  function automatic logic [31:0] mix_col(input logic [31:0] v);
    logic [7:0] a, b, c, d, a2, b2, c2, d2;
    a  = v[31:24];
    b  = v[23:16];
    c  = v[15:8];
    d  = v[7:0];
    a2 = gf_double(a);
    b2 = gf_double(b);
    c2 = gf_double(c);
    d2 = gf_double(d);
    mix_col = {a2 ^ b2 ^ b ^ c ^ d,
               a ^ b2 ^ c2 ^ c ^ d,
               a ^ b ^ c2 ^ d2 ^ d,
               a2 ^ a ^ b ^ c ^ d2};
  endfunction

endpackage

// ----- rtl/aes256_ram.sv -----
// Generic single-port RAM with a registered read.
module aes256_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write at the address, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/aes256_block_encrypt_top.sv -----
// Top level of the AES-256 block encryption engine.
//
// Usage: the 256-bit key is written through the APB port as four 64-bit
// registers at byte addresses 0, 8, 16 and 24, first key byte most
// significant. An item is accepted when start is high and busy is low;
// plain_high and plain_low carry the plaintext block.
// After a key write, the first item expands the schedule: fifteen 128-bit
// round-key rows are written into the key RAM, one row a cycle, before
// that item goes on. The block is captured on acceptance; a load state
// then issues the first key read, and the round state does the initial key
// addition and the fourteen rounds, one round a cycle as the RAM read of
// the next row overlaps the current round. done pulses for one cycle with
// cipher_high and cipher_low, registered from the last round; busy drops
// in that same cycle, so a new item may follow.
// The result is held on the ports until the next item's last round; the
// receiver cannot stall it. Reset clears the key registers to zero and marks
// the schedule as stale, so an item before any key write uses an all-zero key.
module aes256_block_encrypt_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);
  import aes256_pkg::*;
  `include "aes256_block_encrypt_top_macros.svh"

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt;
  logic [63:0]          key_reg [KEY_REGS];
  logic                 keys_ready;
  logic [7:0]           rcon;
  logic [ROW_W-1:0]     prev1, prev2, new_row;
  logic [ROW_W-1:0]     blk, blk_next, rnd_out, rk;
  logic [3:0]           round_count;
  logic                 ram_we;
  logic [ROW_AW-1:0]    ram_addr;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic [31:0]          kt;
  logic [31:0]          nw0, nw1, nw2, nw3;
  logic [31:0]          sc [4];
  logic [31:0]          sh [4];

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = key_reg[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_reg[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_reg[cfg_idx] <= pwdata;
    end
  end

  // Key schedule row: rows 0 and 1 take the key; later even rows rotate and add the round constant.
  always_comb begin
    if (!cnt[0]) begin
      kt = sub_word({prev1[23:0], prev1[31:24]}) ^ {rcon, 24'h0};
    end else begin
      kt = sub_word(prev1[31:0]);
    end
    nw0 = prev2[127:96] ^ kt;
    nw1 = prev2[95:64] ^ nw0;
    nw2 = prev2[63:32] ^ nw1;
    nw3 = prev2[31:0] ^ nw2;
    case (cnt)
      4'd0:    new_row = {key_reg[0], key_reg[1]};
      4'd1:    new_row = {key_reg[2], key_reg[3]};
      default: new_row = {nw0, nw1, nw2, nw3};
    endcase
  end

  // One round: substitution, row shift, mixing (not in the last), key add; cnt 0: key only.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sc[c] = sub_word(blk[127 - 32*c -: 32]);
    end
    for (int c = 0; c < 4; c++) begin
      sh[c] = {sc[c][31:24], sc[(c + 1) % 4][23:16],
               sc[(c + 2) % 4][15:8], sc[(c + 3) % 4][7:0]};
    end
    for (int c = 0; c < 4; c++) begin
      rnd_out[127 - 32*c -: 32] = (cnt == CNT_W'(ROUNDS)) ? sh[c] : mix_col(sh[c]);
    end
    blk_next = ((cnt == '0) ? blk : rnd_out) ^ rk;
  end

  // Round-key memory, one 128-bit row per round.
  aes256_ram #(
    .WIDTH (ROW_W),
    .DEPTH (KEY_ROWS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (new_row),
    .rdata (rk)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = keys_ready ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (cnt == CNT_W'(ROUNDS)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: begin
        if (cnt == CNT_W'(ROUNDS)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    busy     = 1'b1;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_EXPAND: begin
        ram_we   = 1'b1;
        ram_addr = cnt[ROW_AW-1:0];
      end
      ST_LOAD:   ram_addr = '0;
      ST_ROUND:  ram_addr = (cnt == CNT_W'(ROUNDS)) ? '0 : ROW_AW'(cnt + 4'd1);
      default:   busy = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      keys_ready  <= 1'b0;
      done        <= 1'b0;
      round_count <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_ROUND) && (cnt == CNT_W'(ROUNDS));
      case (state)
        ST_IDLE:   cnt <= '0;
        ST_EXPAND: cnt <= (cnt == CNT_W'(ROUNDS)) ? '0 : cnt + 4'd1;
        ST_LOAD:   cnt <= '0;
        ST_ROUND: begin
          cnt         <= cnt + 4'd1;
          round_count <= cnt;
        end
        default:   cnt <= '0;
      endcase
      if (cfg_wr) begin
        keys_ready <= 1'b0;
      end else if (state == ST_EXPAND && cnt == CNT_W'(ROUNDS)) begin
        keys_ready <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      blk  <= {plain_high, plain_low};
      rcon <= RCON_INIT;
    end
    if (state == ST_EXPAND) begin
      prev2 <= prev1;
      prev1 <= new_row;
      if (cnt >= 4'd2 && !cnt[0]) begin
        rcon <= gf_double(rcon);
      end
    end
    if (state == ST_ROUND) begin
      blk <= blk_next;
    end
    if (state == ST_ROUND && cnt == CNT_W'(ROUNDS)) begin
      cipher_high <= blk_next[127:64];
      cipher_low  <= blk_next[63:0];
    end
  end

  // Checks on sequencing.
  `AES256_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `AES256_ASSERT_NOW(a_done_last_round, done, round_count == 4'(ROUNDS))
  `AES256_ASSERT_NEXT(a_cfg_stale, cfg_wr, !keys_ready)
  `AES256_ASSERT_NOW(a_round_keys_ok, state == ST_LOAD, keys_ready)

endmodule
